// File: hdl/fpsa_pkg.sv
// ---------------------------------------------------------------------------
// fpsa_pkg
// shared constants and the binary32 adder function for the tile buffer
// ---------------------------------------------------------------------------
`default_nettype none
package fpsa_pkg;

  localparam int unsigned ZTilesDef   = 2;
  localparam int unsigned XTilesDef   = 2;
  localparam int unsigned YStepsDef   = 4;
  localparam int unsigned ColumnsDef  = 32;
  localparam int unsigned RowBeatsDef = 8;
  localparam int unsigned Lanes       = 4;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef logic [31:0] word_t;

  // leading zero count of a 28 bit value, capped at 27
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // binary32 add, round to nearest even, canonical nan
  function automatic word_t fp_add(input word_t a, input word_t b);
    logic        sa, sb, sbig, ssml, sr;
    logic [7:0]  ea, eb, ebig, esml;
    logic [23:0] ma, mb, mbig, msml;
    logic [27:0] xbig, xsml, sh, sum;
    logic [8:0]  d, er;
    logic [4:0]  lz;
    logic        st, g, r, s, lsb, up;
    logic [24:0] mr;
    logic [27:0] nrm;
    logic        ainf, binf, anan, bnan;
    word_t       res;
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    anan = (ea == 8'hFF) && (a[22:0] != 0);
    bnan = (eb == 8'hFF) && (b[22:0] != 0);
    ainf = (ea == 8'hFF) && (a[22:0] == 0);
    binf = (eb == 8'hFF) && (b[22:0] == 0);
    ma = {ea != 0, a[22:0]};
    mb = {eb != 0, b[22:0]};
    if (ea == 0) ea = 8'd1;
    if (eb == 0) eb = 8'd1;
    if ({ea, ma} >= {eb, mb}) begin
      sbig = sa; ebig = ea; mbig = ma; ssml = sb; esml = eb; msml = mb;
    end else begin
      sbig = sb; ebig = eb; mbig = mb; ssml = sa; esml = ea; msml = ma;
    end
    d = {1'b0, ebig} - {1'b0, esml};
    xbig = {1'b0, mbig, 3'b000};
    xsml = {1'b0, msml, 3'b000};
    if (d > 9'd27) begin
      sh = {27'd0, (msml != 0)};
    end else begin
      sh = xsml >> d[4:0];
      st = 1'b0;
      for (int i = 0; i < 28; i++) begin
        if (i < d && xsml[i]) st = 1'b1;
      end
      sh[0] = sh[0] | st;
    end
    if (sbig == ssml) sum = xbig + sh;
    else sum = xbig - sh;
    sr = sbig;
    er = {1'b0, ebig};
    if (sum[27]) begin
      nrm = {1'b0, sum[27:2], sum[1] | sum[0]};
      er = er + 9'd1;
    end else begin
      lz = lzc28(sum) - 5'd1;
      if (sum == 0) begin
        nrm = 28'd0;
      end else if ({4'd0, lz} >= er) begin
        nrm = sum << (er[4:0] - 5'd1);
        er = 9'd0;
      end else begin
        nrm = sum << lz;
        er = er - {4'd0, lz};
      end
    end
    g = nrm[2]; r = nrm[1]; s = nrm[0];
    lsb = nrm[3];
    up = g & (r | s | lsb);
    mr = {1'b0, nrm[26:3]} + {24'd0, up};
    if (mr[24]) begin
      mr = mr >> 1;
      er = er + 9'd1;
    end
    if (er != 0 && !mr[23]) er = 9'd0;
    if (er == 0 && mr[23]) er = 9'd1;
    if (anan || bnan || (ainf && binf && (sa != sb))) begin
      res = CanonNan;
    end else if (ainf) begin
      res = a;
    end else if (binf) begin
      res = b;
    end else if (sum == 0) begin
      res = {sa & sb, 31'd0};
    end else if (er >= 9'd255) begin
      res = {sr, 8'hFF, 23'd0};
    end else begin
      res = {sr, er[7:0], mr[22:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/fpsa_ram.sv
// ---------------------------------------------------------------------------
// fpsa_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`default_nettype none
module fpsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/float_partial_sum_accumulator.sv
// ---------------------------------------------------------------------------
// float_partial_sum_accumulator
// binary32 tile accumulation buffer with drain and clear
// ---------------------------------------------------------------------------
// usage:
//   in channel (valid/ready) carries one word: mode plus four binary32 lanes
//   mode 0 adds the lanes into the next entry in z, x, y, pair, column, half
//   order; mode 1 reads the next entry in linear order, clears it, and
//   returns it on the out channel with last set on the final entry
// timing:
//   each word passes through the idle, read and write states: clear-check/read
//   issue, ram read, add and write back. one word is in flight at a time, so
//   same-entry hazards cannot arise
//   a drain result is loaded into the output register in the write state;
//   no further word is taken until the receiver takes the result
// reset:
//   counters clear at once, then a clearing pass writes +0 to every entry,
//   one per cycle (Z_TILES*X_TILES*COLUMNS*ROW_BEATS entries, 1024 at the
//   defaults); in_ready_o stays low during that pass
// ---------------------------------------------------------------------------
`default_nettype none
module float_partial_sum_accumulator #(
  parameter int unsigned Z_TILES   = fpsa_pkg::ZTilesDef,
  parameter int unsigned X_TILES   = fpsa_pkg::XTilesDef,
  parameter int unsigned Y_STEPS   = fpsa_pkg::YStepsDef,
  parameter int unsigned COLUMNS   = fpsa_pkg::ColumnsDef,
  parameter int unsigned ROW_BEATS = fpsa_pkg::RowBeatsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         mode_i,
  input  wire  [31:0] lane0_i,
  input  wire  [31:0] lane1_i,
  input  wire  [31:0] lane2_i,
  input  wire  [31:0] lane3_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] out_lane0_o,
  output logic [31:0] out_lane1_o,
  output logic [31:0] out_lane2_o,
  output logic [31:0] out_lane3_o,
  output logic        last_o
);
  import fpsa_pkg::*;

  localparam int unsigned Pairs   = ROW_BEATS / 2;
  localparam int unsigned Entries = Z_TILES * X_TILES * COLUMNS * ROW_BEATS;
  localparam int unsigned AW      = $clog2(Entries);
  localparam int unsigned CW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned PW      = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int unsigned YW      = (Y_STEPS > 1) ? $clog2(Y_STEPS) : 1;
  localparam int unsigned XW      = (X_TILES > 1) ? $clog2(X_TILES) : 1;
  localparam int unsigned ZW      = (Z_TILES > 1) ? $clog2(Z_TILES) : 1;

  // sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic          half_q;
  logic [CW-1:0] col_q;
  logic [PW-1:0] pair_q;
  logic [YW-1:0] ys_q;
  logic [XW-1:0] xt_q;
  logic [ZW-1:0] zt_q;
  logic [AW-1:0] cur_q;
  logic [AW-1:0] addr_q, addr_d;
  logic          drain_q, last_q, skip_q;
  word_t         lane_q [Lanes];
  logic          in_fire, out_fire;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata [Lanes];
  word_t         rdata [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_ram
    fpsa_ram #(.Width(32), .Depth(Entries)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata[l]),
      .raddr_i(addr_q),
      .rdata_o(rdata[l])
    );
  end

  // nothing is taken while a result is still held
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_o;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  // accumulate entry address from the visit counters
  logic [AW+8:0] acc_idx;
  always_comb begin
    acc_idx = (AW+9)'(((32'(zt_q) * X_TILES + 32'(xt_q)) * COLUMNS + 32'(col_q))
              * ROW_BEATS + 32'(pair_q) * 2 + 32'(half_q));
  end

  always_comb begin
    addr_d = addr_q;
    if (in_fire) addr_d = (mode_i == MODE_DRAIN) ? cur_q : acc_idx[AW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (32'(clr_q) == Entries - 1) state_d = ST_IDLE;
      ST_IDLE:  if (in_fire) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // write back: clear pass, drain clear, or accumulated sum
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    for (int l = 0; l < Lanes; l++) wdata[l] = '0;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (state_q == ST_WRITE) begin
      we = !skip_q;
      if (!drain_q) begin
        for (int l = 0; l < Lanes; l++) wdata[l] = fp_add(lane_q[l], rdata[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      half_q      <= 1'b0;
      col_q       <= '0;
      pair_q      <= '0;
      ys_q        <= '0;
      xt_q        <= '0;
      zt_q        <= '0;
      cur_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (out_fire) out_valid_o <= 1'b0;
      if (state_q == ST_WRITE && drain_q) out_valid_o <= 1'b1;
      if (in_fire && mode_i == MODE_DRAIN) begin
        if (32'(cur_q) == Entries - 1) cur_q <= '0;
        else cur_q <= cur_q + AW'(1);
      end
      if (in_fire && mode_i == MODE_ACCUM) begin
        // counters step in order half, column, pair, y, x, z
        half_q <= ~half_q;
        if (half_q) begin
          if (32'(col_q) != COLUMNS - 1) col_q <= col_q + CW'(1);
          else begin
            col_q <= '0;
            if (32'(pair_q) != Pairs - 1) pair_q <= pair_q + PW'(1);
            else begin
              pair_q <= '0;
              if (32'(ys_q) != Y_STEPS - 1) ys_q <= ys_q + YW'(1);
              else begin
                ys_q <= '0;
                if (32'(xt_q) != X_TILES - 1) xt_q <= xt_q + XW'(1);
                else begin
                  xt_q <= '0;
                  if (32'(zt_q) != Z_TILES - 1) zt_q <= zt_q + ZW'(1);
                  else zt_q <= '0;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (in_fire) begin
      drain_q   <= (mode_i == MODE_DRAIN);
      last_q    <= (32'(cur_q) == Entries - 1);
      skip_q    <= (mode_i == MODE_ACCUM) && (32'(acc_idx) >= Entries);
      lane_q[0] <= lane0_i;
      lane_q[1] <= lane1_i;
      lane_q[2] <= lane2_i;
      lane_q[3] <= lane3_i;
    end
    if (state_q == ST_WRITE && drain_q) begin
      out_lane0_o <= rdata[0];
      out_lane1_o <= rdata[1];
      out_lane2_o <= rdata[2];
      out_lane3_o <= rdata[3];
      last_o      <= last_q;
    end
  end

endmodule
`default_nettype wire
